### rtl/core/ssiru_pkg.sv
// Package: sizes, status codes and payload types of the sorted set unit.
`timescale 1ns / 1ps

package ssiru_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
  } in_data_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 is_empty;
  } out_data_t;

endpackage

### rtl/core/ssiru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssiru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sorted_unique_set_insert_remove_unit.sv
// Top level: ordered set of unique signed values with insert and remove.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/in_data) carries one transaction per
//   operation: action (0 insert, 1 remove) and a signed 32-bit value.
//   Output channel (out_valid/out_ready/out_data) returns exactly one
//   transaction per operation: status, count held afterwards, empty flag.
//   Entries live in a CAPACITY-deep RAM in ascending order. One shared
//   compare walks the RAM from index 0, one entry per cycle with the read
//   pipelined, until the first entry not below the value. Insert then
//   moves larger entries up, remove moves them down, one entry per cycle
//   through the same RAM port pair.
//   in_ready is high only while idle, which is in the cycle after the
//   result is loaded, so a new operation is not accepted until the
//   previous one has been loaded into the output register.
//   A remove on an empty set skips the search and goes to S_DONE.
//   Reset (rst_n low, synchronous) empties the set and drops any pending
//   result; RAM contents need no clearing as only written entries are read.
//   Output stall: the result sits in an output register; the next
//   operation is accepted and processed meanwhile, and its result waits
//   until the register is taken.

module sorted_unique_set_insert_remove_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssiru_pkg::in_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssiru_pkg::out_data_t out_data
);

  import ssiru_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_INS    = 5'b00100,
    S_REM    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [VALUE_W-1:0]   key_r, key_nxt;        // value with sign bit flipped
  logic                 act_r, act_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;        // next RAM read index
  logic [CNT_W-1:0]     pos_r, pos_nxt;        // insert position
  logic                 dv_r, dv_nxt;          // rdata holds a live entry
  logic [ADDR_W-1:0]    wa_r, wa_nxt;          // move target of that entry
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_data_t            out_r, out_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [VALUE_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  logic [CNT_W-1:0]     idx_inc, idx_dec, stop_pos;
  logic                 ent_lt, ent_eq;

  ssiru_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY),
    .AW    (ADDR_W)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  // the shared compare: unsigned on flipped keys gives the signed order
  assign ent_lt   = ram_rdata < key_r;
  assign ent_eq   = ram_rdata == key_r;
  assign stop_pos = (dv_r && !ent_lt) ? idx_dec : held_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    key_nxt       = key_r;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    dv_nxt        = dv_r;
    wa_nxt        = wa_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = wa_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = {~in_data.value[VALUE_W-1], in_data.value[VALUE_W-2:0]};
          act_nxt = in_data.action;
          idx_nxt = '0;
          dv_nxt  = 1'b0;
          if (in_data.action == ACT_REMOVE && held_r == '0) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if ((dv_r && !ent_lt) || idx_r == held_r) begin
          // position found; entry matches only if the walk stopped on it
          dv_nxt = 1'b0;
          if (act_r == ACT_INSERT) begin
            if (dv_r && !ent_lt && ent_eq) begin
              status_nxt = ST_DUPLICATE;
              state_nxt  = S_DONE;
            end else if (held_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = stop_pos;
              idx_nxt   = held_r;
              state_nxt = S_INS;
            end
          end else begin
            if (dv_r && !ent_lt && ent_eq) begin
              idx_nxt   = idx_r;       // stop_pos + 1
              state_nxt = S_REM;
            end else begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end
          end
        end else begin
          ram_raddr = idx_r[ADDR_W-1:0];
          idx_nxt   = idx_inc;
          dv_nxt    = 1'b1;
        end
      end

      S_INS: begin
        // move entry read last cycle one slot up
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (idx_r != pos_r) begin
          ram_raddr = idx_dec[ADDR_W-1:0];
          wa_nxt    = idx_r[ADDR_W-1:0];
          idx_nxt   = idx_dec;
          dv_nxt    = 1'b1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            ram_we     = 1'b1;
            ram_waddr  = pos_r[ADDR_W-1:0];
            ram_wdata  = key_r;
            held_nxt   = held_r + CNT_W'(1);
            status_nxt = ST_INSERTED;
            state_nxt  = S_DONE;
          end
        end
      end

      S_REM: begin
        // move entry read last cycle one slot down
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (idx_r < held_r) begin
          ram_raddr = idx_r[ADDR_W-1:0];
          wa_nxt    = idx_dec[ADDR_W-1:0];
          idx_nxt   = idx_inc;
          dv_nxt    = 1'b1;
        end else begin
          dv_nxt     = 1'b0;
          held_nxt   = held_r - CNT_W'(1);
          status_nxt = ST_REMOVED;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_nxt.status   = status_r;
          out_nxt.count    = COUNT_W'(held_r);
          out_nxt.is_empty = (held_r == '0);
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    act_r    <= act_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    wa_r     <= wa_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule

### rtl/core/ssiru_checker.sv
// Port-level checker for the sorted set unit, bound to the top level.
`timescale 1ns / 1ps

module ssiru_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input ssiru_pkg::out_data_t out_data
);

  import ssiru_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.is_empty)
    else $error("set empty reported with entries held");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_INSERTED ||
                  out_data.status == ST_DUPLICATE ||
                  out_data.status == ST_FULL) |-> !out_data.is_empty)
    else $error("set empty after insert outcome");

endmodule

bind sorted_unique_set_insert_remove_unit ssiru_checker u_ssiru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
